// ----- rtl/lsr_pkg.sv -----
// Package for the light sensor reader: payload types, bus program and byte helpers.
package lsr_pkg;

	// Request codes carried in the mode field.
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_MEASURE = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_COMMAND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_COMMAND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD     = 2'd3;
	localparam int CFG_DATA_W = 10;

	// Sequencer step values.
	localparam logic [4:0] STEP_IDLE    = 5'd31;
	localparam logic [4:0] STEP_MEASURE = 5'd0;
	localparam logic [4:0] STEP_READ    = 5'd9;

	// floor(y / 6) for y below 2^19 as (y * LUX_RECIP) >> LUX_SHIFT.
	localparam logic [19:0] LUX_RECIP = 20'd699051;
	localparam int LUX_SHIFT = 22;

	typedef enum logic [3:0] {
		OP_START  = 4'd0,
		OP_STOP   = 4'd1,
		OP_SADDR  = 4'd2,
		OP_SPOW   = 4'd3,
		OP_SMEAS  = 4'd4,
		OP_SRADDR = 4'd5,
		OP_RHI    = 4'd6,
		OP_RLO    = 4'd7,
		OP_ENDM   = 4'd8,
		OP_ENDR   = 4'd9
	} lsr_op_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       sda_in;
	} lsr_in_t;

	typedef struct packed {
		logic        scl_out;
		logic        sda_out;
		logic        busy_res;
		logic [15:0] lux_level;
		logic        lux_valid;
	} lsr_out_t;

	typedef struct packed {
		logic [7:0] write_address;
		logic [7:0] power_command;
		logic [7:0] measure_command;
		logic [9:0] half_period;
	} lsr_cfg_t;

	// Bus program: measure frames from step 0, read frame from step 9.
	function automatic lsr_op_t prog_op(input logic [3:0] step);
		lsr_op_t op;
		unique case (step)
			4'd0:    op = OP_START;
			4'd1:    op = OP_SADDR;
			4'd2:    op = OP_SPOW;
			4'd3:    op = OP_STOP;
			4'd4:    op = OP_START;
			4'd5:    op = OP_SADDR;
			4'd6:    op = OP_SMEAS;
			4'd7:    op = OP_STOP;
			4'd8:    op = OP_ENDM;
			4'd9:    op = OP_START;
			4'd10:   op = OP_SRADDR;
			4'd11:   op = OP_RHI;
			4'd12:   op = OP_RLO;
			4'd13:   op = OP_STOP;
			4'd14:   op = OP_ENDR;
			default: op = OP_ENDM;
		endcase
		return op;
	endfunction

	// A step is busy when it names a bus operation rather than an end marker.
	function automatic logic step_busy(input logic [4:0] step);
		lsr_op_t op;
		op = prog_op(step[3:0]);
		return !step[4] && (op != OP_ENDM) && (op != OP_ENDR);
	endfunction

	// Byte loaded into the shifter when an operation begins.
	function automatic logic [7:0] load_byte(input lsr_op_t op, input lsr_cfg_t cfg);
		logic [7:0] b;
		unique case (op)
			OP_SADDR:  b = cfg.write_address;
			OP_SRADDR: b = cfg.write_address + 8'd1;
			OP_SPOW:   b = cfg.power_command;
			OP_SMEAS:  b = cfg.measure_command;
			default:   b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/lsr_lux_conv.sv -----
// Raw reading to lux conversion, floor(raw * 5 / 6), by reciprocal multiplication.
module lsr_lux_conv
	import lsr_pkg::*;
(
	input  logic [15:0] raw,
	output logic [15:0] lux
);

	logic [18:0] raw_x5;
	logic [38:0] prod;

	// Five times the reading, then one multiply by the scaled reciprocal of six.
	assign raw_x5 = 19'(raw) + {1'b0, raw, 2'b00};
	assign prod   = 39'(raw_x5) * 39'(LUX_RECIP);
	assign lux    = prod[LUX_SHIFT+15:LUX_SHIFT];

endmodule

// ----- rtl/lsr_seq.sv -----
// Bus sequencer: holds the frame state and works out one tick's line levels and result.
module lsr_seq
	import lsr_pkg::*;
#(
	parameter int TICK_BITS = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  lsr_in_t  item,
	input  lsr_cfg_t cfg,
	output lsr_out_t res
);

	localparam logic [16:0] TMAX = 17'((1 << TICK_BITS) - 1);

	logic [4:0]           step_q, st;
	logic [3:0]           phase_q, ph;
	logic [3:0]           bit_q, bi;
	logic [TICK_BITS-1:0] tick_q, tc;
	logic [7:0]           shift_q, sh;
	logic [15:0]          raw_q, raw;
	logic [15:0]          lux_q, lux;
	logic [15:0]          lux_calc;
	logic [16:0]          half, hp, tc_inc;
	logic [3:0]           nst;
	lsr_op_t              op, nop;
	logic                 recv, sendb, do_finish;

	lsr_lux_conv u_lux (
		.raw (raw_q),
		.lux (lux_calc)
	);

	// Effective half period: zero counts as one, saturated to the tick counter.
	always_comb begin
		half = 17'(cfg.half_period);
		if (half == 17'd0) begin
			hp = 17'd1;
		end else if (half > TMAX) begin
			hp = TMAX;
		end else begin
			hp = half;
		end
	end

	// One tick of the sequencer.
	always_comb begin
		st        = step_q;
		ph        = phase_q;
		bi        = bit_q;
		tc        = tick_q;
		sh        = shift_q;
		raw       = raw_q;
		lux       = lux_q;
		op        = OP_ENDM;
		nop       = OP_ENDM;
		nst       = 4'd0;
		recv      = 1'b0;
		sendb     = 1'b0;
		do_finish = 1'b0;
		tc_inc    = 17'(tick_q) + 17'd1;
		res.scl_out   = 1'b1;
		res.sda_out   = 1'b1;
		res.busy_res  = 1'b0;
		res.lux_valid = 1'b0;

		// A new request is taken only when idle, and drives its first phase at once.
		if (!step_busy(st)) begin
			st = STEP_IDLE;
			if (item.mode == MODE_MEASURE) begin
				st = STEP_MEASURE;
			end else if (item.mode == MODE_READ) begin
				st = STEP_READ;
			end
			ph = 4'd0;
			bi = 4'd0;
			tc = '0;
			sh = load_byte(prog_op(st[3:0]), cfg);
		end

		if (step_busy(st)) begin
			res.busy_res = 1'b1;
			op     = prog_op(st[3:0]);
			recv   = (op == OP_RHI) || (op == OP_RLO);
			sendb  = !recv && (op != OP_START) && (op != OP_STOP);
			tc_inc = 17'(tc) + 17'd1;

			// Line levels for this phase.
			priority if (op == OP_START) begin
				res.scl_out = (ph < 4'd2);
				res.sda_out = (ph == 4'd0);
			end else if (op == OP_STOP) begin
				res.scl_out = (ph >= 4'd1);
				res.sda_out = (ph == 4'd2);
			end else begin
				res.scl_out = ph[0];
				if (bi < 4'd8) begin
					res.sda_out = sendb ? sh[7] : 1'b1;
				end else begin
					res.sda_out = sendb ? 1'b1 : (op != OP_RHI);
				end
			end

			// Phase timing, bit shifting and operation hand-over.
			if (tc_inc >= hp) begin
				tc = '0;
				if ((op == OP_START) || (op == OP_STOP)) begin
					ph = ph + 4'd1;
					do_finish = (ph >= 4'd3);
				end else if (ph == 4'd0) begin
					ph = 4'd1;
				end else begin
					if (bi < 4'd8) begin
						if (recv) begin
							sh = {sh[6:0], item.sda_in};
						end else if (sendb) begin
							sh = {sh[6:0], 1'b0};
						end
					end
					if (recv && (bi == 4'd7)) begin
						if (op == OP_RHI) begin
							raw[15:8] = sh;
						end else begin
							raw[7:0] = sh;
						end
					end
					ph = 4'd0;
					bi = bi + 4'd1;
					do_finish = (bi >= 4'd9);
				end

				if (do_finish) begin
					nst = st[3:0] + 4'd1;
					nop = prog_op(nst);
					if (nop == OP_ENDR) begin
						lux = lux_calc;
						st  = STEP_IDLE;
						res.lux_valid = 1'b1;
					end else if (nop == OP_ENDM) begin
						st = STEP_IDLE;
					end else begin
						st = {1'b0, nst};
						ph = 4'd0;
						bi = 4'd0;
						tc = '0;
						sh = load_byte(nop, cfg);
					end
				end
			end else begin
				tc = tc + TICK_BITS'(1);
			end
		end

		res.lux_level = lux;
	end

	// State registers, stepped once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			phase_q <= 4'd0;
			bit_q   <= 4'd0;
			tick_q  <= '0;
			shift_q <= 8'd0;
			raw_q   <= 16'd0;
			lux_q   <= 16'd0;
		end else if (adv) begin
			step_q  <= st;
			phase_q <= ph;
			bit_q   <= bi;
			tick_q  <= tc;
			shift_q <= sh;
			raw_q   <= raw;
			lux_q   <= lux;
		end
	end

	// A completed reading always ends the sequence.
	a_valid_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.lux_valid |=> step_q == STEP_IDLE)
		else $error("lux result without return to idle");

	// A finished reading is only reported from a busy tick.
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.lux_valid |-> res.busy_res)
		else $error("lux result outside a sequence");

	// Both lines are released whenever no sequence runs.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		!res.busy_res |-> res.scl_out && res.sda_out)
		else $error("bus driven while idle");

	// While a sequence runs, the stored phase and bit position stay within a frame.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_busy(step_q) |-> (phase_q < 4'd3) && (bit_q < 4'd9))
		else $error("phase or bit index out of range");

endmodule

// ----- rtl/light_sensor_i2c_reader.sv -----
// Top level of the light sensor reader: input register, configuration, sequencer and result register.
// Each request is one tick of the bus timing and yields exactly one result with the SCL and SDA
// drive, the busy flag and the latest lux value. One request is taken per clock cycle unless the
// result register is held by out_ready: a request goes into an input register, the sequencer works
// out the tick in one pass of logic, and the outcome lands in a result register, so the rate is
// set only by how fast results are taken. A measure request sends the power-on and one-shot
// commands in two write frames; a read request fetches two bytes and gives floor(raw * 5 / 6).
// Every SCL phase lasts half_period ticks, a zero half_period counting as one. Configuration
// writes are always accepted and must be made while no sequence or request is in flight.
module light_sensor_i2c_reader
	import lsr_pkg::*;
#(
	parameter int TICK_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lsr_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lsr_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lsr_cfg_t cfg_q;
	lsr_in_t  in_s1;
	logic     valid_s1;
	lsr_out_t res;
	lsr_out_t out_q;
	logic     out_valid_q;
	logic     adv;

	// The tick in the input register moves on when the result register is free.
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_address   <= 8'd70;
			cfg_q.power_command   <= 8'd1;
			cfg_q.measure_command <= 8'd32;
			cfg_q.half_period     <= 10'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WRITE_ADDRESS:   cfg_q.write_address   <= cfg_data[7:0];
				CFG_POWER_COMMAND:   cfg_q.power_command   <= cfg_data[7:0];
				CFG_MEASURE_COMMAND: cfg_q.measure_command <= cfg_data[7:0];
				CFG_HALF_PERIOD:     cfg_q.half_period     <= cfg_data;
				default:             cfg_q.half_period     <= cfg_q.half_period;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	lsr_seq #(
		.TICK_BITS (TICK_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (in_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

endmodule
